FILE: hdl/indexed_double_ended_queue_assert.svh
// assertion helpers used by the deque back part
`ifndef INDEXED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define INDEXED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define IDQ_ASSERT_IMP(name, clk, rst, lhs, rhs) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("idq assertion failed");

// next-cycle implication
`define IDQ_ASSERT_NXT(name, clk, rst, lhs, rhs) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("idq assertion failed");

`endif

FILE: hdl/idq_pkg.sv
`timescale 1ns / 1ps
package idq_pkg;

   typedef enum logic [2:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_READ_AT    = 3'd2,
      KIND_WRITE_AT   = 3'd3,
      KIND_READ_FRONT = 3'd4,
      KIND_READ_BACK  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;

   // work handed from the front part to the back part, minus the ring slot
   typedef struct packed {
      op_type              op;
      status_type          status;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic [DATA_W-1:0]   value;
   } entry_type;

endpackage

FILE: hdl/idq_req_if.sv
`timescale 1ns / 1ps
interface idq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic [9:0]         index;
   logic signed [31:0] value;

   modport source (output valid, output kind, output index, output value, input ready);
   modport sink (input valid, input kind, input index, input value, output ready);
endinterface

FILE: hdl/idq_rsp_if.sv
`timescale 1ns / 1ps
interface idq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] data;
   logic [1:0]         status;
   logic [10:0]        count;
   logic               is_empty;

   modport source (output valid, output data, output status, output count, output is_empty,
                   input ready);
   modport sink (input valid, input data, input status, input count, input is_empty,
                 output ready);
endinterface

FILE: hdl/idq_front.sv
`timescale 1ns / 1ps
module idq_front #(
   parameter int unsigned CAPACITY = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   idq_req_if.sink                             req_if,
   input  logic                                queue_full,
   output logic                                queue_push,
   output logic [$clog2(CAPACITY)-1:0]         queue_slot,
   output idq_pkg::entry_type                  queue_entry
);

   localparam int unsigned SLOT_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W  = (CNT_W > idq_pkg::COUNT_W) ? CNT_W : idq_pkg::COUNT_W;
   localparam logic [SLOT_W:0]   CAP_SUM  = (SLOT_W + 1)'(CAPACITY);
   localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);

   logic [SLOT_W-1:0] front_pos_ff, front_pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic                 accept;
   idq_pkg::kind_type    kind;
   logic                 is_full, is_empty, idx_ok;
   logic [CMP_W-1:0]     idx_w, cnt_w, next_cnt_w;
   logic [SLOT_W-1:0]    logical, dec_front, last_off, slot;
   logic [SLOT_W:0]      sum, wrapped;
   logic [CNT_W-1:0]     next_cnt, cnt_minus;
   logic [SLOT_W-1:0]    next_front;
   idq_pkg::op_type      op;
   idq_pkg::status_type  status;
   logic                 use_dec;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;
   assign kind         = idq_pkg::kind_type'(req_if.kind);

   assign is_full   = (count_ff == CAP_CNT);
   assign is_empty  = (count_ff == '0);
   assign idx_w     = CMP_W'(req_if.index);
   assign cnt_w     = CMP_W'(count_ff);
   assign idx_ok    = (idx_w < cnt_w);
   assign cnt_minus = count_ff - CNT_W'(1);
   assign last_off  = cnt_minus[SLOT_W-1:0];
   assign dec_front = (front_pos_ff == '0) ? LAST_POS : front_pos_ff - SLOT_W'(1);

   // ring slot of a logical position, both operands below capacity
   assign sum     = {1'b0, front_pos_ff} + {1'b0, logical};
   assign wrapped = (sum >= CAP_SUM) ? sum - CAP_SUM : sum;
   assign slot    = use_dec ? dec_front : wrapped[SLOT_W-1:0];

   always_comb begin
      op         = idq_pkg::OP_NONE;
      status     = idq_pkg::STATUS_OK;
      logical    = '0;
      use_dec    = 1'b0;
      next_cnt   = count_ff;
      next_front = front_pos_ff;
      unique case (kind)
         idq_pkg::KIND_PUSH_FRONT: begin
            if (is_full) begin
               status = idq_pkg::STATUS_FULL;
            end else begin
               op         = idq_pkg::OP_WRITE;
               use_dec    = 1'b1;
               next_front = dec_front;
               next_cnt   = count_ff + CNT_W'(1);
            end
         end
         idq_pkg::KIND_PUSH_BACK: begin
            logical = count_ff[SLOT_W-1:0];
            if (is_full) begin
               status = idq_pkg::STATUS_FULL;
            end else begin
               op       = idq_pkg::OP_WRITE;
               next_cnt = count_ff + CNT_W'(1);
            end
         end
         idq_pkg::KIND_READ_AT, idq_pkg::KIND_WRITE_AT: begin
            logical = idx_w[SLOT_W-1:0];
            if (!idx_ok) begin
               status = idq_pkg::STATUS_RANGE;
            end else if (kind == idq_pkg::KIND_READ_AT) begin
               op = idq_pkg::OP_READ;
            end else begin
               op = idq_pkg::OP_WRITE;
            end
         end
         idq_pkg::KIND_READ_FRONT, idq_pkg::KIND_READ_BACK: begin
            logical = (kind == idq_pkg::KIND_READ_BACK) ? last_off : '0;
            if (is_empty) begin
               status = idq_pkg::STATUS_RANGE;
            end else begin
               op = idq_pkg::OP_READ;
            end
         end
         default: begin
            status = idq_pkg::STATUS_RANGE;
         end
      endcase
   end

   assign next_cnt_w = CMP_W'(next_cnt);

   assign queue_push           = accept;
   assign queue_slot           = slot;
   assign queue_entry.op       = op;
   assign queue_entry.status   = status;
   assign queue_entry.count    = next_cnt_w[idq_pkg::COUNT_W-1:0];
   assign queue_entry.is_empty = (next_cnt == '0);
   assign queue_entry.value    = req_if.value;

   assign front_pos_in = accept ? next_front : front_pos_ff;
   assign count_in     = accept ? next_cnt : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_pos_ff <= '0;
         count_ff     <= '0;
      end else begin
         front_pos_ff <= front_pos_in;
         count_ff     <= count_in;
      end
   end

endmodule

FILE: hdl/idq_fifo.sv
`timescale 1ns / 1ps
module idq_fifo #(
   parameter int unsigned WIDTH = 58
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]                   entries_ff [idq_pkg::QUEUE_DEPTH];
   logic [idq_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [idq_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [idq_pkg::QUEUE_PTR_W:0]      fill_ff, fill_in;

   localparam logic [idq_pkg::QUEUE_PTR_W:0] DEPTH_CNT =
      (idq_pkg::QUEUE_PTR_W + 1)'(idq_pkg::QUEUE_DEPTH);
   localparam logic [idq_pkg::QUEUE_PTR_W-1:0] PTR_ONE  = (idq_pkg::QUEUE_PTR_W)'(1);
   localparam logic [idq_pkg::QUEUE_PTR_W:0]   FILL_ONE = (idq_pkg::QUEUE_PTR_W + 1)'(1);

   assign full     = (fill_ff == DEPTH_CNT);
   assign valid    = (fill_ff != '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_ONE : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_ONE : rd_ptr_ff;

   always_comb begin
      fill_in = fill_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + FILL_ONE;
         2'b01:   fill_in = fill_ff - FILL_ONE;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: hdl/idq_back.sv
`timescale 1ns / 1ps
`include "indexed_double_ended_queue_assert.svh"
module idq_back #(
   parameter int unsigned CAPACITY = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_valid,
   input  logic [$clog2(CAPACITY)-1:0]   queue_slot,
   input  idq_pkg::entry_type            queue_entry,
   output logic                          queue_pop,
   idq_rsp_if.source                     rsp_if
);

   logic [idq_pkg::DATA_W-1:0] mem [CAPACITY];

   logic                        s1_valid_ff, s1_valid_in;
   idq_pkg::entry_type          s1_entry_ff;
   logic [idq_pkg::DATA_W-1:0]  rd_data_ff;

   logic                        out_valid_ff, out_valid_in;
   logic [idq_pkg::DATA_W-1:0]  out_data_ff;
   idq_pkg::status_type         out_status_ff;
   logic [idq_pkg::COUNT_W-1:0] out_count_ff;
   logic                        out_empty_ff;

   logic advance;

   // output register free or being drained this cycle
   assign advance   = !out_valid_ff || rsp_if.ready;
   assign queue_pop = queue_valid && (!s1_valid_ff || advance);

   assign s1_valid_in  = queue_pop ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   // one memory access per request, read data registered
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         if (queue_entry.op == idq_pkg::OP_WRITE) begin
            mem[queue_slot] <= queue_entry.value;
         end
         rd_data_ff  <= mem[queue_slot];
         s1_entry_ff <= queue_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_data_ff   <= (s1_entry_ff.op == idq_pkg::OP_READ) ? rd_data_ff : '0;
         out_status_ff <= s1_entry_ff.status;
         out_count_ff  <= s1_entry_ff.count;
         out_empty_ff  <= s1_entry_ff.is_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.data     = out_data_ff;
   assign rsp_if.status   = out_status_ff;
   assign rsp_if.count    = out_count_ff;
   assign rsp_if.is_empty = out_empty_ff;

   `IDQ_ASSERT_IMP(a_pop_has_entry, clock, reset, queue_pop, queue_valid)
   `IDQ_ASSERT_IMP(a_no_overrun, clock, reset, s1_valid_ff && !advance, !queue_pop)
   `IDQ_ASSERT_IMP(a_error_zero, clock, reset,
      out_valid_ff && out_status_ff != idq_pkg::STATUS_OK, out_data_ff == '0)
   `IDQ_ASSERT_NXT(a_read_is_ok, clock, reset,
      queue_pop && queue_entry.op == idq_pkg::OP_READ,
      s1_valid_ff && s1_entry_ff.status == idq_pkg::STATUS_OK)

endmodule

FILE: hdl/indexed_double_ended_queue.sv
`timescale 1ns / 1ps
// indexed deque of signed 32-bit words held in a ring buffer of CAPACITY entries
// req_if: one request per handshake (kind, index, value); kinds are push front,
//   push back, read at index, write at index, read front and read back
// rsp_if: exactly one response per request, in request order, carrying data,
//   status, element count after the request and an empty flag
// path: an accepted request passes the queue entry, the memory access and the
//   output register in that order before its response is valid
// throughput: one request per cycle while responses are taken; each request
//   makes one access to the single-port element memory
// a four-entry queue sits between the decode stage and the memory stage, so
//   requests keep flowing while rsp_if.ready is low; once the queue and
//   pipeline are full, req_if.ready drops until responses drain
// reset clears the front pointer, the element count, the queue and the
//   pipeline; the element memory is not cleared and is ready at once
module indexed_double_ended_queue #(
   parameter int unsigned CAPACITY = 1024
) (
   input  logic       clock,
   input  logic       reset,
   idq_req_if.sink    req_if,
   idq_rsp_if.source  rsp_if
);

   localparam int unsigned SLOT_W  = $clog2(CAPACITY);
   localparam int unsigned ENTRY_W = $bits(idq_pkg::entry_type);
   localparam int unsigned Q_W     = SLOT_W + ENTRY_W;

   logic                 queue_full, queue_push, queue_pop, queue_valid;
   logic [SLOT_W-1:0]    push_slot, pop_slot;
   idq_pkg::entry_type   push_entry, pop_entry;
   logic [Q_W-1:0]       push_data, pop_data;

   idq_front #(.CAPACITY(CAPACITY)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_slot  (push_slot),
      .queue_entry (push_entry)
   );

   assign push_data = {push_slot, push_entry};

   idq_fifo #(.WIDTH(Q_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .pop_data  (pop_data)
   );

   assign pop_slot  = pop_data[Q_W-1:ENTRY_W];
   assign pop_entry = idq_pkg::entry_type'(pop_data[ENTRY_W-1:0]);

   idq_back #(.CAPACITY(CAPACITY)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_slot  (pop_slot),
      .queue_entry (pop_entry),
      .queue_pop   (queue_pop),
      .rsp_if      (rsp_if)
   );

endmodule

FILE: tb/tb_indexed_double_ended_queue.sv
`timescale 1ns / 1ps
module tb_indexed_double_ended_queue;

   localparam int unsigned CAPACITY    = 1024;
   localparam logic [2:0]  KIND_SPARE_A = 3'd6;
   localparam logic [2:0]  KIND_SPARE_B = 3'd7;
   localparam int unsigned PHASE_ITEMS = 250;
   localparam int unsigned PRINT_LIMIT = 40;

   typedef struct {
      logic [31:0]          data;
      idq_pkg::status_type  status;
      logic [10:0]          count;
      logic                 is_empty;
   } deque_response_type;

   logic clock = 1'b0;
   logic reset;

   idq_req_if req_if();
   idq_rsp_if rsp_if();

   indexed_double_ended_queue #(.CAPACITY(CAPACITY)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // deque as the block should hold it
   logic [31:0]        model_ring [CAPACITY];
   int unsigned        model_front = 0;
   int unsigned        model_count = 0;
   deque_response_type expected_responses[$];

   int unsigned mismatch_count = 0;
   int unsigned sent_elements  = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned ring_slot(int unsigned logical);
      return (model_front + logical) % CAPACITY;
   endfunction

   function automatic deque_response_type deque_apply(logic [2:0] kind, logic [9:0] index,
                                                      logic [31:0] value);
      deque_response_type r;
      r.data   = '0;
      r.status = idq_pkg::STATUS_OK;
      case (kind)
         idq_pkg::KIND_PUSH_FRONT, idq_pkg::KIND_PUSH_BACK: begin
            if (model_count >= CAPACITY) begin
               r.status = idq_pkg::STATUS_FULL;
            end else if (kind == idq_pkg::KIND_PUSH_FRONT) begin
               model_front = (model_front + CAPACITY - 1) % CAPACITY;
               model_ring[model_front] = value;
               model_count++;
            end else begin
               model_ring[ring_slot(model_count)] = value;
               model_count++;
            end
         end
         idq_pkg::KIND_READ_AT: begin
            if (index >= model_count) r.status = idq_pkg::STATUS_RANGE;
            else r.data = model_ring[ring_slot(index)];
         end
         idq_pkg::KIND_WRITE_AT: begin
            if (index >= model_count) r.status = idq_pkg::STATUS_RANGE;
            else model_ring[ring_slot(index)] = value;
         end
         idq_pkg::KIND_READ_FRONT: begin
            if (model_count == 0) r.status = idq_pkg::STATUS_RANGE;
            else r.data = model_ring[ring_slot(0)];
         end
         idq_pkg::KIND_READ_BACK: begin
            if (model_count == 0) r.status = idq_pkg::STATUS_RANGE;
            else r.data = model_ring[ring_slot(model_count - 1)];
         end
         default: r.status = idq_pkg::STATUS_RANGE;
      endcase
      r.count    = model_count[10:0];
      r.is_empty = (model_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // responses are checked before the request of the same edge is predicted
   always @(posedge clock) begin : track_deque
      deque_response_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("response with no request pending", rsp_if.data, '0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_if.data !== want.data)
                  report_mismatch("data", rsp_if.data, want.data);
               if (rsp_if.status !== want.status)
                  report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
               if (rsp_if.count !== want.count)
                  report_mismatch("count", 32'(rsp_if.count), 32'(want.count));
               if (rsp_if.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_if.is_empty), 32'(want.is_empty));
            end
         end
         if (req_if.valid && req_if.ready)
            expected_responses.insert(expected_responses.size(),
                                      deque_apply(req_if.kind, req_if.index, req_if.value));
      end
   end

   task automatic send_request(logic [2:0] kind, logic [9:0] index, logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind  <= kind;
      req_if.index <= index;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // element tally for choosing indexes, kept apart from the checker
      if ((kind == idq_pkg::KIND_PUSH_FRONT || kind == idq_pkg::KIND_PUSH_BACK) &&
          sent_elements < CAPACITY)
         sent_elements++;
   endtask

   task automatic drain_responses();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int unsigned pick;
      logic [2:0]  kind;
      logic [9:0]  index;
      logic [31:0] value;
      pick = $urandom_range(99);
      if (pick < 33) kind = idq_pkg::KIND_PUSH_FRONT;
      else if (pick < 65) kind = idq_pkg::KIND_PUSH_BACK;
      else if (pick < 77) kind = idq_pkg::KIND_READ_AT;
      else if (pick < 87) kind = idq_pkg::KIND_WRITE_AT;
      else if (pick < 92) kind = idq_pkg::KIND_READ_FRONT;
      else if (pick < 97) kind = idq_pkg::KIND_READ_BACK;
      else kind = $urandom_range(1) ? KIND_SPARE_B : KIND_SPARE_A;
      // mostly in range, sometimes anywhere
      if (sent_elements != 0 && $urandom_range(9) < 8)
         index = 10'($urandom_range(sent_elements - 1));
      else
         index = 10'($urandom_range(CAPACITY - 1));
      case ($urandom_range(15))
         0:       value = 32'h8000_0000;
         1:       value = 32'h7fff_ffff;
         2:       value = 32'h0000_0000;
         3:       value = 32'hffff_ffff;
         default: value = $urandom;
      endcase
      send_request(kind, index, value);
   endtask

   task automatic test_empty_deque();
      send_request(idq_pkg::KIND_READ_FRONT, 10'd0, 32'h0);
      send_request(idq_pkg::KIND_READ_BACK, 10'd0, 32'h0);
      send_request(idq_pkg::KIND_READ_AT, 10'd0, 32'h0);
      send_request(idq_pkg::KIND_READ_AT, 10'd1023, 32'h0);
      send_request(idq_pkg::KIND_WRITE_AT, 10'd0, 32'h5555_aaaa);
      send_request(KIND_SPARE_A, 10'd1023, 32'hffff_ffff);
      send_request(KIND_SPARE_B, 10'd0, 32'h0);
   endtask

   task automatic test_push_and_access();
      // first push front wraps the front pointer below slot zero
      send_request(idq_pkg::KIND_PUSH_FRONT, 10'd0, 32'h7fff_ffff);
      send_request(idq_pkg::KIND_PUSH_BACK, 10'd1023, 32'h8000_0000);
      send_request(idq_pkg::KIND_PUSH_FRONT, 10'd0, 32'h0);
      send_request(idq_pkg::KIND_PUSH_BACK, 10'd0, 32'hffff_ffff);
      send_request(idq_pkg::KIND_READ_FRONT, 10'd0, 32'h0);
      send_request(idq_pkg::KIND_READ_BACK, 10'd0, 32'h0);
      for (int i = 0; i < 4; i++) send_request(idq_pkg::KIND_READ_AT, 10'(i), 32'h0);
      send_request(idq_pkg::KIND_WRITE_AT, 10'd3, 32'h1234_5678);
      send_request(idq_pkg::KIND_READ_AT, 10'd3, 32'h0);
      send_request(idq_pkg::KIND_READ_AT, 10'd4, 32'h0);
      send_request(idq_pkg::KIND_WRITE_AT, 10'd4, 32'hdead_beef);
      // sender holds off until every response is back
      drain_responses();
   endtask

   task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (PHASE_ITEMS) random_request();
      drain_responses();
   endtask

   task automatic test_full_deque();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (sent_elements < CAPACITY)
         send_request(idq_pkg::KIND_PUSH_BACK, 10'd0, $urandom);
      send_request(idq_pkg::KIND_PUSH_FRONT, 10'd0, 32'h1111_1111);
      send_request(idq_pkg::KIND_PUSH_BACK, 10'd0, 32'h2222_2222);
      send_request(idq_pkg::KIND_READ_AT, 10'd1023, 32'h0);
      send_request(idq_pkg::KIND_WRITE_AT, 10'd1023, 32'h8000_0000);
      send_request(idq_pkg::KIND_READ_BACK, 10'd0, 32'h0);
      send_request(idq_pkg::KIND_READ_FRONT, 10'd0, 32'h0);
      send_idle_pct = 37;
      rsp_stall_pct = 37;
      repeat (40) random_request();
      drain_responses();
   endtask

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind  = idq_pkg::KIND_READ_FRONT;
      req_if.index = '0;
      req_if.value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_deque();
      test_push_and_access();
      test_random_traffic(0, 0);
      test_random_traffic(51, 0);
      test_random_traffic(0, 51);
      test_random_traffic(37, 37);
      test_full_deque();

      rsp_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("tb_indexed_double_ended_queue: PASS");
      end else begin
         $display("tb_indexed_double_ended_queue: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_indexed_double_ended_queue: FAIL");
      $finish;
   end

endmodule
